/* rtl/pbq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the paged buffer issue/retire queue.
// No dependencies; used by the entry memory and the top level.
package pbq_pkg;

  // Fixed widths of the transaction fields.
  localparam int TAG_PORT_W = 16;
  localparam int PAGE_W     = 8;
  localparam int PAGE_MAX   = 255;

  typedef enum logic [1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_ISSUE   = 2'd1,
    FUNC_RETIRE  = 2'd2,
    FUNC_FLUSH   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

/* rtl/paged_buffer_issue_retire_queue.sv */
`timescale 1ns / 1ps
// Paged buffer issue/retire queue. Buffers (tag plus page count) are queued in order; issue
// hands out pages of the oldest buffer not yet fully issued, retire counts completed pages at
// the head and reports the tag when the head buffer is done, and flush reports every queued
// buffer in order, one result each. Each enqueue, issue or retire transaction first reads the
// addressed entry from the synchronous entry memory, then computes the result and updates the
// pointers. Flush first reads the head entry, then delivers one buffer per step, each result's
// step also reading the entry behind it. A finished result sits in an output register, so a
// stalled output only delays the next transaction once it wants to deliver. Depends on pbq_pkg
// and pbq_mem.
module paged_buffer_issue_retire_queue
  import pbq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_PAGES   = 255,
  parameter int TAG_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [TAG_PORT_W-1:0] buffer_tag,
  input  logic [PAGE_W-1:0]     page_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [TAG_PORT_W-1:0] tag_out,
  output logic [PAGE_W-1:0]     page_index,
  output logic                  first_page,
  output logic                  buffer_done,
  output logic                  last
);

  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W      = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam int PAGE_CAP_I = (MAX_PAGES > PAGE_MAX) ? PAGE_MAX : MAX_PAGES;

  localparam logic [PAGE_W-1:0] PAGE_CAP  = PAGE_W'(PAGE_CAP_I);
  localparam logic [PAGE_W-1:0] PAGE_ONE  = PAGE_W'(1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  state_t             state, state_next;
  func_t              op_func;
  logic [TAG_W-1:0]   op_tag;
  logic [PAGE_W-1:0]  op_pages;
  logic [IDX_W-1:0]   head_index, head_index_next;
  logic [IDX_W-1:0]   issue_index, issue_index_next;
  logic [IDX_W-1:0]   tail_index, tail_index_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [CNT_W-1:0]   unissued_count, unissued_count_next;
  logic [PAGE_W-1:0]  issue_page, issue_page_next;
  logic [PAGE_W-1:0]  retire_page, retire_page_next;

  logic               in_accept;
  logic               can_emit;
  logic               emit;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [TAG_W-1:0]   rd_tag;
  logic [PAGE_W-1:0]  rd_pages;
  logic               wr_en;
  logic [PAGE_W-1:0]  pages_eff;
  logic               outstanding;

  status_t            res_status;
  logic [TAG_W-1:0]   res_tag;
  logic [PAGE_W-1:0]  res_page;
  logic               res_first;
  logic               res_done;
  logic               res_last;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && (state == ST_IDLE);
  assign can_emit  = !out_valid || !out_stall;

  assign pages_eff = (op_pages == '0)      ? PAGE_ONE :
                     (op_pages > PAGE_CAP) ? PAGE_CAP : op_pages;

  always_comb begin
    if (entry_count == '0) begin
      outstanding = 1'b0;
    end else if (entry_count > unissued_count) begin
      outstanding = 1'b1;
    end else begin
      outstanding = (retire_page != issue_page);
    end
  end

  pbq_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .TAG_W  (TAG_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (tail_index),
    .wr_tag   (op_tag),
    .wr_pages (pages_eff),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_tag   (rd_tag),
    .rd_pages (rd_pages)
  );

  // Execute step. The memory is written only here and read only at accept or at the
  // next flush step, so a read never meets a write to the same slot in one cycle.
  always_comb begin
    state_next          = state;
    head_index_next     = head_index;
    issue_index_next    = issue_index;
    tail_index_next     = tail_index;
    entry_count_next    = entry_count;
    unissued_count_next = unissued_count;
    issue_page_next     = issue_page;
    retire_page_next    = retire_page;
    emit       = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = (func_t'(func) == FUNC_ISSUE) ? issue_index : head_index;
    res_status = STAT_DONE;
    res_tag    = '0;
    res_page   = '0;
    res_first  = 1'b0;
    res_done   = 1'b0;
    res_last   = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          rd_en      = 1'b1;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (can_emit) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          case (op_func)
            FUNC_ENQUEUE: begin
              if (entry_count >= DEPTH_CNT) begin
                res_status = STAT_FULL;
              end else begin
                wr_en = 1'b1;
                if (entry_count == '0) begin
                  head_index_next  = tail_index;
                  issue_index_next = tail_index;
                  issue_page_next  = PAGE_ONE;
                  retire_page_next = PAGE_ONE;
                end else if (unissued_count == '0) begin
                  issue_index_next = tail_index;
                  issue_page_next  = PAGE_ONE;
                end
                tail_index_next     = next_slot(tail_index);
                entry_count_next    = entry_count + CNT_ONE;
                unissued_count_next = unissued_count + CNT_ONE;
              end
            end

            FUNC_ISSUE: begin
              if (unissued_count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_tag   = rd_tag;
                res_page  = issue_page;
                res_first = (issue_page == PAGE_ONE);
                if (issue_page >= rd_pages) begin
                  issue_index_next    = next_slot(issue_index);
                  unissued_count_next = unissued_count - CNT_ONE;
                  issue_page_next     = PAGE_ONE;
                end else begin
                  issue_page_next = issue_page + PAGE_ONE;
                end
              end
            end

            FUNC_RETIRE: begin
              if (!outstanding) begin
                res_status = STAT_EMPTY;
              end else if (retire_page >= rd_pages) begin
                res_tag          = rd_tag;
                res_done         = 1'b1;
                head_index_next  = next_slot(head_index);
                entry_count_next = entry_count - CNT_ONE;
                retire_page_next = PAGE_ONE;
              end else begin
                retire_page_next = retire_page + PAGE_ONE;
              end
            end

            default: begin
              // Flush reports one buffer per pass, re-reading the memory at the new head.
              if (entry_count == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_tag  = rd_tag;
                res_done = 1'b1;
                if (entry_count == CNT_ONE) begin
                  head_index_next     = tail_index;
                  issue_index_next    = tail_index;
                  entry_count_next    = '0;
                  unissued_count_next = '0;
                  issue_page_next     = PAGE_ONE;
                  retire_page_next    = PAGE_ONE;
                end else begin
                  res_last         = 1'b0;
                  head_index_next  = next_slot(head_index);
                  entry_count_next = entry_count - CNT_ONE;
                  rd_en            = 1'b1;
                  rd_addr          = next_slot(head_index);
                  state_next       = ST_EXEC;
                end
              end
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head_index     <= '0;
      issue_index    <= '0;
      tail_index     <= '0;
      entry_count    <= '0;
      unissued_count <= '0;
      issue_page     <= PAGE_ONE;
      retire_page    <= PAGE_ONE;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      head_index     <= head_index_next;
      issue_index    <= issue_index_next;
      tail_index     <= tail_index_next;
      entry_count    <= entry_count_next;
      unissued_count <= unissued_count_next;
      issue_page     <= issue_page_next;
      retire_page    <= retire_page_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_func  <= func_t'(func);
      op_tag   <= buffer_tag[TAG_W-1:0];
      op_pages <= page_count;
    end
    if (emit) begin
      status      <= res_status;
      tag_out     <= TAG_PORT_W'(res_tag);
      page_index  <= res_page;
      first_page  <= res_first;
      buffer_done <= res_done;
      last        <= res_last;
    end
  end

endmodule

/* rtl/pbq_mem.sv */
`timescale 1ns / 1ps
// Entry store of the queue: tag and page count for each slot.
// One write port, one read port with registered read data. Uses pbq_pkg.
module pbq_mem
  import pbq_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int TAG_W  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TAG_W-1:0]  wr_tag,
  input  logic [PAGE_W-1:0] wr_pages,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [TAG_W-1:0]  rd_tag,
  output logic [PAGE_W-1:0] rd_pages
);

  localparam int WORD_W = TAG_W + PAGE_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_tag, wr_pages};
    end
  end

  // Read data holds when no read is issued, so a stalled result keeps its operands.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_tag   = rd_data[WORD_W-1:PAGE_W];
  assign rd_pages = rd_data[PAGE_W-1:0];

endmodule
